@@ src/vgt_pkg.sv @@
// Shared constants, register codes and helpers for the vertical gradient tint block.
`default_nettype none

package vgt_pkg;

  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NCH       = 3;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CFG_H_W   = 13;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned PROD_W    = 2 * CH_W;

  localparam logic [CH_W-1:0] WHITE_LEVEL = 8'd243;
  localparam logic [CH_W-1:0] FULL_SCALE  = 8'd255;

  localparam logic [COLOR_W-1:0] TOP_RESET    = '0;
  localparam logic [COLOR_W-1:0] BOTTOM_RESET = '0;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd1;

  typedef enum logic [1:0] {
    REG_TOP    = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // floor(x / 255), exact for any product of two 8-bit values
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
    return sum[PROD_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

@@ src/vertical_gradient_tint.sv @@
// Pipelined vertical gradient tint with APB register port.
// Pipeline: 13 register stages from input beat to output beat.
// Throughput: one beat per cycle while out_ready_i is high; per-stage valid bits, stalls fill bubbles.
// Depth set by the gradient divide: eight restoring steps, one per stage.
// Reset clears all stage valid bits; colors reset to 0, height to 1.
`default_nettype none

module vertical_gradient_tint #(
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vgt_pkg::ADDR_W-1:0]    paddr,
  input  logic [vgt_pkg::DATA_W-1:0]    pwdata,
  output logic [vgt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vgt_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic [vgt_pkg::ROW_W-1:0]     row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vgt_pkg::PIX_W-1:0]     pixel_out_o
);
  import vgt_pkg::*;

  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW   = (HW > CFG_H_W) ? HW : CFG_H_W;
  localparam int unsigned RW   = (HW > ROW_W) ? HW : ROW_W;
  localparam int unsigned NUMW = HW + CH_W;
  localparam int unsigned NDIV = CH_W;
  localparam int unsigned NST  = NDIV + 5;
  localparam int unsigned SDIV = 2;
  localparam int unsigned SMUL = SDIV + NDIV + 1;
  localparam int unsigned SOUT = NST - 1;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] m;
  } side_t;

  // config registers
  logic [COLOR_W-1:0] top_q, bottom_q;
  logic [CFG_H_W-1:0] height_q;
  reg_idx_e           cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= TOP_RESET;
      bottom_q <= BOTTOM_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TOP:    top_q    <= pwdata[COLOR_W-1:0];
        REG_BOTTOM: bottom_q <= pwdata[COLOR_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TOP:    prdata = {{(DATA_W-COLOR_W){1'b0}}, top_q};
      REG_BOTTOM: prdata = {{(DATA_W-COLOR_W){1'b0}}, bottom_q};
      REG_HEIGHT: prdata = {{(DATA_W-CFG_H_W){1'b0}}, height_q};
      default:    prdata = '0;
    endcase
  end

  // stage valids and enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[SOUT];

  side_t side_q [0:SMUL];

  // stage 0: effective height, row clamp, channel max
  logic [CW-1:0]   h_cfg, h_sat;
  logic [HW-1:0]   h_eff, r_sat;
  logic [RW-1:0]   r_ext, h_ext;
  logic [CH_W-1:0] m_rg, m_all;
  logic [HW-1:0]   h_q [0:SDIV+NDIV-1];
  logic [HW-1:0]   r0_q;

  always_comb begin
    h_cfg = CW'(height_q);
    if (h_cfg == '0) begin
      h_sat = CW'(1);
    end else if (h_cfg > CW'(MAX_HEIGHT)) begin
      h_sat = CW'(MAX_HEIGHT);
    end else begin
      h_sat = h_cfg;
    end
    h_eff = HW'(h_sat);
    r_ext = RW'(row_i);
    h_ext = RW'(h_eff);
    r_sat = (r_ext > h_ext) ? h_eff : HW'(r_ext);
    m_rg  = (pixel_in_i[23:16] > pixel_in_i[15:8]) ? pixel_in_i[23:16] : pixel_in_i[15:8];
    m_all = (m_rg > pixel_in_i[7:0]) ? m_rg : pixel_in_i[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= '{alpha: pixel_in_i[31:24], m: m_all};
      h_q[0]    <= h_eff;
      r0_q      <= r_sat;
    end
  end

  // stage 1: gradient products; stage 2: numerator
  logic [NUMW-1:0] ptop_q [NCH];
  logic [NUMW-1:0] pbot_q [NCH];
  logic [NUMW-1:0] rem_q  [0:NDIV-1][NCH];
  logic [CH_W-1:0] quo_q  [1:NDIV][NCH];
  logic [HW-1:0]   hr_diff;

  assign hr_diff = h_q[0] - r0_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= side_q[0];
      h_q[1]    <= h_q[0];
      for (int c = 0; c < NCH; c++) begin
        ptop_q[c] <= NUMW'(top_q[CH_W*c +: CH_W]) * NUMW'(hr_diff);
        pbot_q[c] <= NUMW'(bottom_q[CH_W*c +: CH_W]) * NUMW'(r0_q);
      end
    end
    if (en[SDIV]) begin
      side_q[SDIV] <= side_q[1];
      h_q[SDIV]    <= h_q[1];
      for (int c = 0; c < NCH; c++) begin
        rem_q[0][c] <= ptop_q[c] + pbot_q[c];
      end
    end
  end

  // restoring divide by height, one quotient bit per stage, msb first
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int unsigned BIT = NDIV - j;
    logic [NUMW-1:0] trial;
    logic [NCH-1:0]  ge;
    logic [CH_W-1:0] q_prev [NCH];

    assign trial = NUMW'(h_q[SDIV+j-1]) << BIT;

    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        ge[c] = rem_q[j-1][c] >= trial;
        if (j == 1) begin
          q_prev[c] = '0;
        end else begin
          q_prev[c] = quo_q[(j == 1) ? 1 : j-1][c];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[SDIV+j]) begin
        side_q[SDIV+j] <= side_q[SDIV+j-1];
        for (int c = 0; c < NCH; c++) begin
          quo_q[j][c] <= q_prev[c] | (CH_W'(ge[c]) << BIT);
        end
      end
    end

    if (j < NDIV) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[SDIV+j]) begin
          h_q[SDIV+j] <= h_q[SDIV+j-1];
          for (int c = 0; c < NCH; c++) begin
            rem_q[j][c] <= ge[c] ? (rem_q[j-1][c] - trial) : rem_q[j-1][c];
          end
        end
      end
    end
  end

  // intensity scale; a channel max at or above WHITE_LEVEL multiplies by 255 so the divide returns the target
  logic [PROD_W-1:0] prod_q [NCH];
  logic [CH_W-1:0]   scale;
  logic [PIX_W-1:0]  pix_q;

  assign scale = (side_q[SMUL-1].m >= WHITE_LEVEL) ? FULL_SCALE : side_q[SMUL-1].m;

  always_ff @(posedge clk_i) begin
    if (en[SMUL]) begin
      side_q[SMUL] <= side_q[SMUL-1];
      for (int c = 0; c < NCH; c++) begin
        prod_q[c] <= PROD_W'(quo_q[NDIV][c]) * PROD_W'(scale);
      end
    end
    if (en[SOUT]) begin
      pix_q[PIX_W-1 -: CH_W] <= side_q[SMUL].alpha;
      for (int c = 0; c < NCH; c++) begin
        pix_q[CH_W*c +: CH_W] <= div255(prod_q[c]);
      end
    end
  end

  assign pixel_out_o = pix_q;

endmodule

`default_nettype wire
